[src/adsr_pkg.sv]
// ----------------------------------------------------------------------------
// adsr_pkg
// shared types, codes and field widths of the adsr envelope generator
// ----------------------------------------------------------------------------
package adsr_pkg;

   // fixed field widths
   localparam int STEP_W     = 17;   // step and sustain level registers
   localparam int REPEAT_W   = 3;
   localparam int DIV_W      = 16;
   localparam int CMD_W      = 3;
   localparam int PHASE_W    = 3;    // phase code on the result word
   localparam int CSR_ADDR_W = 3;

   // event codes
   typedef enum logic [CMD_W-1:0] {
      CMD_TICK       = 3'd0,
      CMD_KEY_ON     = 3'd1,
      CMD_KEY_OFF    = 3'd2,
      CMD_STOP       = 3'd3,
      CMD_SET_ENABLE = 3'd4
   } cmd_type;

   // repeat mode codes
   localparam logic [REPEAT_W-1:0] RP_NONE    = 3'd0;
   localparam logic [REPEAT_W-1:0] RP_ATTACK  = 3'd1;
   localparam logic [REPEAT_W-1:0] RP_DECAY   = 3'd2;
   localparam logic [REPEAT_W-1:0] RP_SUSTAIN = 3'd3;
   localparam logic [REPEAT_W-1:0] RP_RELEASE = 3'd4;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_ATTACK_STEP    = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_DECAY_STEP     = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_SUSTAIN_STEP   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_RELEASE_STEP   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_SUSTAIN_TARGET = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_REPEAT_MODE    = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_TICK_DIVIDER   = 3'd6;

   // phase codes as seen on the result word
   localparam logic [PHASE_W-1:0] PHC_OFF     = 3'd0;
   localparam logic [PHASE_W-1:0] PHC_ATTACK  = 3'd1;
   localparam logic [PHASE_W-1:0] PHC_DECAY   = 3'd2;
   localparam logic [PHASE_W-1:0] PHC_SUSTAIN = 3'd3;
   localparam logic [PHASE_W-1:0] PHC_SUSUP   = 3'd4;
   localparam logic [PHASE_W-1:0] PHC_RELEASE = 3'd5;

   // envelope phase state machine
   typedef enum logic [5:0] {
      PH_OFF     = 6'b000001,
      PH_ATTACK  = 6'b000010,
      PH_DECAY   = 6'b000100,
      PH_SUSTAIN = 6'b001000,
      PH_SUSUP   = 6'b010000,
      PH_RELEASE = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [STEP_W-1:0]   attack_step;
      logic [STEP_W-1:0]   decay_step;
      logic [STEP_W-1:0]   sustain_step;
      logic [STEP_W-1:0]   release_step;
      logic [STEP_W-1:0]   sustain_target;
      logic [REPEAT_W-1:0] repeat_mode;
      logic [DIV_W-1:0]    tick_divider;
   } cfg_type;

   typedef struct packed {
      phase_type phase;
      logic      active;
      logic      gate;
   } env_flags_type;

   function automatic logic [PHASE_W-1:0] phase_code(input phase_type ph);
      logic [PHASE_W-1:0] code;
      case (ph)
         PH_ATTACK:  code = PHC_ATTACK;
         PH_DECAY:   code = PHC_DECAY;
         PH_SUSTAIN: code = PHC_SUSTAIN;
         PH_SUSUP:   code = PHC_SUSUP;
         PH_RELEASE: code = PHC_RELEASE;
         default:    code = PHC_OFF;
      endcase
      return code;
   endfunction

endpackage

[src/adsr_cfg_regs.sv]
// ----------------------------------------------------------------------------
// adsr_cfg_regs
// register file for envelope rates, sustain level, repeat mode and divider
// ----------------------------------------------------------------------------
module adsr_cfg_regs (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             wr_en,
   input  logic [adsr_pkg::CSR_ADDR_W-1:0]  wr_addr,
   input  logic [adsr_pkg::STEP_W-1:0]      wr_data,
   output adsr_pkg::cfg_type                cfg
);

   adsr_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_addr)
            adsr_pkg::CSR_ATTACK_STEP:    cfg_in.attack_step    = wr_data;
            adsr_pkg::CSR_DECAY_STEP:     cfg_in.decay_step     = wr_data;
            adsr_pkg::CSR_SUSTAIN_STEP:   cfg_in.sustain_step   = wr_data;
            adsr_pkg::CSR_RELEASE_STEP:   cfg_in.release_step   = wr_data;
            adsr_pkg::CSR_SUSTAIN_TARGET: cfg_in.sustain_target = wr_data;
            adsr_pkg::CSR_REPEAT_MODE:
               cfg_in.repeat_mode = wr_data[adsr_pkg::REPEAT_W-1:0];
            adsr_pkg::CSR_TICK_DIVIDER:
               cfg_in.tick_divider = wr_data[adsr_pkg::DIV_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[src/adsr_env_core.sv]
// ----------------------------------------------------------------------------
// adsr_env_core
// envelope state registers and their one-pass next-state logic
// ----------------------------------------------------------------------------
module adsr_env_core #(
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,      // apply one event
   input  logic [adsr_pkg::CMD_W-1:0]    cmd,
   input  logic                          legato,
   input  logic                          enable_value,
   input  adsr_pkg::cfg_type             cfg,
   output logic [FRAC_BITS:0]            level,
   output adsr_pkg::env_flags_type       flags
);

   localparam int LEVEL_W = FRAC_BITS + 1;
   localparam int SUM_W   =
      ((LEVEL_W > adsr_pkg::STEP_W) ? LEVEL_W : adsr_pkg::STEP_W) + 1;

   logic [LEVEL_W-1:0]          level_ff, level_in;
   adsr_pkg::phase_type         phase_ff, phase_in;
   logic [adsr_pkg::DIV_W-1:0]  div_ff, div_in;
   logic                        en_ff, en_in;
   logic                        gate_ff, gate_in;

   logic [SUM_W-1:0]            one, lvl, sus_raw, sl, sum_up;
   logic [SUM_W-1:0]            dec_lvl, sus_lvl, rel_lvl, lvl_next;
   logic [SUM_W-1:0]            atk_ext, dec_ext, sst_ext, rel_ext;
   logic [adsr_pkg::REPEAT_W-1:0] rp;

   assign one     = SUM_W'(1) << FRAC_BITS;
   assign lvl     = SUM_W'(level_ff);
   assign atk_ext = SUM_W'(cfg.attack_step);
   assign dec_ext = SUM_W'(cfg.decay_step);
   assign sst_ext = SUM_W'(cfg.sustain_step);
   assign rel_ext = SUM_W'(cfg.release_step);
   assign sus_raw = SUM_W'(cfg.sustain_target);
   assign sl      = (sus_raw > one) ? one : sus_raw;
   assign rp      = (cfg.repeat_mode > adsr_pkg::RP_RELEASE) ? adsr_pkg::RP_RELEASE
                                                             : cfg.repeat_mode;

   // candidate levels, saturating at zero on the way down
   assign sum_up  = lvl + atk_ext;
   assign dec_lvl = (lvl > dec_ext) ? lvl - dec_ext : '0;
   assign sus_lvl = (lvl > sst_ext) ? lvl - sst_ext : '0;
   assign rel_lvl = (lvl > rel_ext) ? lvl - rel_ext : '0;

   always_comb begin
      lvl_next = lvl;
      phase_in = phase_ff;
      div_in   = div_ff;
      en_in    = en_ff;
      gate_in  = gate_ff;
      case (cmd)
         adsr_pkg::CMD_TICK: begin
            if (en_ff) begin
               if (div_ff != '0) begin
                  div_in = div_ff - 1'b1;
               end else begin
                  div_in = cfg.tick_divider;
                  case (phase_ff)
                     adsr_pkg::PH_ATTACK: begin
                        lvl_next = sum_up;
                        if (sum_up >= one) begin
                           if (rp == adsr_pkg::RP_ATTACK) begin
                              lvl_next = '0;
                           end else begin
                              lvl_next = one;
                              phase_in = adsr_pkg::PH_DECAY;
                           end
                        end
                     end
                     adsr_pkg::PH_DECAY: begin
                        lvl_next = dec_lvl;
                        if (dec_lvl <= sl) begin
                           lvl_next = sl;
                           phase_in = (rp == adsr_pkg::RP_DECAY) ? adsr_pkg::PH_ATTACK
                                                                 : adsr_pkg::PH_SUSTAIN;
                        end
                     end
                     adsr_pkg::PH_SUSTAIN: begin
                        lvl_next = sus_lvl;
                        if (!gate_ff) begin
                           phase_in = (rp == adsr_pkg::RP_SUSTAIN) ? adsr_pkg::PH_ATTACK
                                                                   : adsr_pkg::PH_RELEASE;
                        end else if (sus_lvl == '0) begin
                           phase_in = (rp == adsr_pkg::RP_SUSTAIN) ? adsr_pkg::PH_ATTACK
                                                                   : adsr_pkg::PH_OFF;
                        end
                     end
                     adsr_pkg::PH_SUSUP: begin
                        lvl_next = sum_up;
                        if (!gate_ff) begin
                           if (sum_up > one) lvl_next = one;
                           phase_in = (rp == adsr_pkg::RP_SUSTAIN) ? adsr_pkg::PH_ATTACK
                                                                   : adsr_pkg::PH_RELEASE;
                        end else if (sum_up >= sl) begin
                           lvl_next = sl;
                           phase_in = adsr_pkg::PH_SUSTAIN;
                        end
                     end
                     adsr_pkg::PH_RELEASE: begin
                        lvl_next = rel_lvl;
                        if (rel_lvl == '0) begin
                           phase_in = (rp == adsr_pkg::RP_RELEASE) ? adsr_pkg::PH_ATTACK
                                                                   : adsr_pkg::PH_OFF;
                        end
                     end
                     default: begin
                        // off phase update shuts the operator down
                        lvl_next = '0;
                        en_in    = 1'b0;
                        gate_in  = 1'b0;
                     end
                  endcase
               end
            end
         end
         adsr_pkg::CMD_KEY_ON: begin
            en_in = 1'b1;
            if (phase_ff == adsr_pkg::PH_OFF) begin
               div_in = cfg.tick_divider;
            end
            if (phase_ff == adsr_pkg::PH_OFF || !legato) begin
               phase_in = adsr_pkg::PH_ATTACK;
               gate_in  = 1'b1;
            end
         end
         adsr_pkg::CMD_KEY_OFF: begin
            if (rp == adsr_pkg::RP_SUSTAIN) begin
               phase_in = adsr_pkg::PH_ATTACK;
               gate_in  = 1'b1;
            end else begin
               phase_in = adsr_pkg::PH_RELEASE;
               gate_in  = 1'b0;
            end
         end
         adsr_pkg::CMD_STOP: begin
            en_in    = 1'b0;
            phase_in = adsr_pkg::PH_OFF;
            lvl_next = '0;
            gate_in  = 1'b0;
         end
         adsr_pkg::CMD_SET_ENABLE: begin
            en_in = enable_value;
         end
         default: ;
      endcase
   end

   // level never passes one, so the low bits carry it whole
   assign level_in = lvl_next[LEVEL_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
         phase_ff <= adsr_pkg::PH_OFF;
         div_ff   <= '0;
         en_ff    <= 1'b0;
         gate_ff  <= 1'b0;
      end else if (step) begin
         level_ff <= level_in;
         phase_ff <= phase_in;
         div_ff   <= div_in;
         en_ff    <= en_in;
         gate_ff  <= gate_in;
      end
   end

   assign level        = level_ff;
   assign flags.phase  = phase_ff;
   assign flags.active = en_ff;
   assign flags.gate   = gate_ff;

endmodule

[src/adsr_envelope_generator.sv]
// ----------------------------------------------------------------------------
// adsr_envelope_generator
// synth operator envelope generator with attack, decay, sustain and release
// ----------------------------------------------------------------------------
// One event word goes in per cycle while the result side keeps up (tick, key
// on, key off, stop, set enable) and one result word comes out per event,
// carrying level, phase, the enabled flag and the gate flag as they stand
// after that event. Sustained rate is one word per clock while results are
// taken: an event waits in the input register, the envelope update (one add
// or saturating subtract, a compare against one or the sustain level, and
// the phase select) runs in a single pass, and the envelope state registers
// double as the result register. An accepted event passes through the input
// register and then the state registers. The result side may stall freely;
// the input register keeps taking a new word whenever the pending result is
// taken in the same cycle. Level is unsigned fixed point with one equal to
// 2^FRAC_BITS and saturates at zero on the way down. Configuration writes
// are taken at any time on the csr channel and should be made while no
// event is in flight.
// ----------------------------------------------------------------------------
module adsr_envelope_generator #(
   parameter int FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // event channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [0] legato, [1] enable_value
   input  logic [adsr_pkg::CMD_W-1:0]        req_tuser,   // [2:0] command
   // result channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // level [FRAC_BITS:0], phase [+2:+0], active, gate, zero padded to bytes
   output logic [((FRAC_BITS+1+adsr_pkg::PHASE_W+2+7)/8)*8-1:0] rsp_tdata,
   // configuration write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [adsr_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [adsr_pkg::STEP_W-1:0]       csr_wdata
);

   localparam int LEVEL_W = FRAC_BITS + 1;
   localparam int RSP_W   = ((LEVEL_W + adsr_pkg::PHASE_W + 2 + 7) / 8) * 8;

   // input register
   logic                        in_valid_ff, in_valid_in;
   logic [adsr_pkg::CMD_W-1:0]  cmd_ff;
   logic                        legato_ff;
   logic                        enable_ff;

   // result valid flag
   logic                        out_valid_ff, out_valid_in;

   logic                        advance;
   logic                        req_take;

   adsr_pkg::cfg_type           cfg;
   logic [LEVEL_W-1:0]          level;
   adsr_pkg::env_flags_type     flags;

   // csr writes never stall
   assign csr_ready = 1'b1;

   adsr_cfg_regs u_cfg (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (csr_valid),
      .wr_addr (csr_addr),
      .wr_data (csr_wdata),
      .cfg     (cfg)
   );

   // event leaves the input register when the result slot is free or freeing
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload of the input register
   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff    <= req_tuser;
         legato_ff <= req_tdata[0];
         enable_ff <= req_tdata[1];
      end
   end

   adsr_env_core #(
      .FRAC_BITS (FRAC_BITS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .cmd          (cmd_ff),
      .legato       (legato_ff),
      .enable_value (enable_ff),
      .cfg          (cfg),
      .level        (level),
      .flags        (flags)
   );

   // state registers hold the result until it is taken
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_W'({flags.gate, flags.active,
                               adsr_pkg::phase_code(flags.phase), level});

   // level shown never exceeds one
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (level <= (LEVEL_W'(1) << FRAC_BITS)))
      else $error("envelope level above one");

   // stop clears the envelope
   a_stop_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && cmd_ff == adsr_pkg::CMD_STOP) |=>
         (flags.phase == adsr_pkg::PH_OFF && level == '0 && !flags.gate && !flags.active))
      else $error("stop did not clear the envelope");

   // plain key on restarts attack with the gate held
   a_key_on_attack: assert property (@(posedge clock) disable iff (reset)
      (advance && cmd_ff == adsr_pkg::CMD_KEY_ON && !legato_ff) |=>
         (flags.phase == adsr_pkg::PH_ATTACK && flags.gate && flags.active))
      else $error("key on did not start attack");

   // a held event is not dropped while the result side stalls
   a_input_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(cmd_ff)))
      else $error("pending event lost");

endmodule

[dv/adsr_envelope_generator_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// adsr_envelope_generator_test
// self-checking bench for the adsr envelope generator
// ----------------------------------------------------------------------------
// Event words are queued by the stimulus block and handed to the block by a
// falling-edge driver. A rising-edge monitor keeps a shadow envelope and its
// register copy, works out the level, phase and flags after every accepted
// event, and compares each result word against the oldest prediction. The
// run walks through a directed opening and then several register settings,
// including all-zero and all-ones ones, under different idle and stall mixes.
// ----------------------------------------------------------------------------
module adsr_envelope_generator_test;

   localparam int STEP_W       = adsr_pkg::STEP_W;
   localparam int REPEAT_W     = adsr_pkg::REPEAT_W;
   localparam int DIV_W        = adsr_pkg::DIV_W;
   localparam int CMD_W        = adsr_pkg::CMD_W;
   localparam int PHASE_W      = adsr_pkg::PHASE_W;
   localparam int CSR_ADDR_W   = adsr_pkg::CSR_ADDR_W;

   localparam int FRAC_BITS    = 16;
   localparam int RSP_W        = ((FRAC_BITS + 1 + PHASE_W + 2 + 7) / 8) * 8;
   localparam int LVL_W        = FRAC_BITS + 2;    // one spare bit for the attack sum
   localparam int QUIET_LIMIT  = 4000;
   localparam int HOLDOFF_LEN  = 400;
   localparam int PHASE_COUNT  = 8;
   localparam int PHASE_ITEMS  = 180;
   localparam int TAIL_CYCLES  = 8;

   localparam logic [LVL_W-1:0]      LEVEL_ONE  = LVL_W'(1) << FRAC_BITS;
   localparam logic [STEP_W-1:0]     STEP_MAX   = '1;
   localparam logic [CSR_ADDR_W-1:0] CSR_UNUSED = 3'd7;
   // command codes the block must ignore
   localparam logic [CMD_W-1:0]      CMD_SPARE_FIRST = 3'd5;
   localparam logic [CMD_W-1:0]      CMD_SPARE_LAST  = 3'd7;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic             legato;
      logic             enable_value;
   } command_word_type;

   typedef struct packed {
      logic [FRAC_BITS:0]   level;
      logic [PHASE_W-1:0]   phase;
      logic                 active;
      logic                 gate;
   } envelope_word_type;

   // dut inputs, all known from time zero
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = '0;   // [0] legato, [1] enable_value
   logic [CMD_W-1:0]      req_tuser  = '0;   // [2:0] command
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;         // level, phase, active, gate
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [STEP_W-1:0]     csr_wdata  = '0;

   // stimulus bookkeeping
   command_word_type  command_queue[$];
   envelope_word_type envelope_queue[$];
   command_word_type  next_command;
   int                commands_queued   = 0;
   int                commands_accepted = 0;
   int                req_idle_pct      = 0;
   int                rsp_stall_pct     = 0;
   int                holdoff_requests  = 0;
   int                holdoffs_served   = 0;
   int                holdoff_left      = 0;
   int                mismatch_count    = 0;
   int                quiet_cycles      = 0;
   logic              req_word_taken    = 1'b0;

   // shadow envelope state and register copy
   adsr_pkg::cfg_type  shadow_cfg     = '0;
   logic [LVL_W-1:0]   shadow_level   = '0;
   logic [PHASE_W-1:0] shadow_phase   = adsr_pkg::PHC_OFF;
   logic [DIV_W-1:0]   shadow_divider = '0;
   logic               shadow_enabled = 1'b0;
   logic               shadow_gate    = 1'b0;

   adsr_envelope_generator #(
      .FRAC_BITS (FRAC_BITS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // shadow envelope
   // ------------------------------------------------------------------------

   // decrement that stops at zero instead of wrapping
   function automatic logic [LVL_W-1:0] sat_sub(input logic [LVL_W-1:0] a,
                                                input logic [LVL_W-1:0] b);
      return (a > b) ? a - b : '0;
   endfunction

   // one divider step, and one envelope update when the divider has run out
   function automatic void advance_envelope();
      logic [LVL_W-1:0]    sus_lim;
      logic [REPEAT_W-1:0] rp;
      sus_lim = LVL_W'(shadow_cfg.sustain_target);
      if (sus_lim > LEVEL_ONE) begin
         sus_lim = LEVEL_ONE;
      end
      rp = (shadow_cfg.repeat_mode > adsr_pkg::RP_RELEASE) ? adsr_pkg::RP_RELEASE
                                                           : shadow_cfg.repeat_mode;
      if (shadow_divider != '0) begin
         shadow_divider = shadow_divider - 1'b1;
      end else begin
         shadow_divider = shadow_cfg.tick_divider;
         case (shadow_phase)
            adsr_pkg::PHC_ATTACK: begin
               shadow_level = shadow_level + LVL_W'(shadow_cfg.attack_step);
               if (shadow_level >= LEVEL_ONE) begin
                  // attack looping restarts from silence
                  shadow_level = (rp == adsr_pkg::RP_ATTACK) ? '0 : LEVEL_ONE;
                  shadow_phase = (rp == adsr_pkg::RP_ATTACK) ? adsr_pkg::PHC_ATTACK
                                                             : adsr_pkg::PHC_DECAY;
               end
            end
            adsr_pkg::PHC_DECAY: begin
               shadow_level = sat_sub(shadow_level, LVL_W'(shadow_cfg.decay_step));
               if (shadow_level <= sus_lim) begin
                  shadow_level = sus_lim;
                  shadow_phase = (rp == adsr_pkg::RP_DECAY) ? adsr_pkg::PHC_ATTACK
                                                            : adsr_pkg::PHC_SUSTAIN;
               end
            end
            adsr_pkg::PHC_SUSTAIN: begin
               shadow_level = sat_sub(shadow_level, LVL_W'(shadow_cfg.sustain_step));
               if (!shadow_gate) begin
                  shadow_phase = (rp == adsr_pkg::RP_SUSTAIN) ? adsr_pkg::PHC_ATTACK
                                                              : adsr_pkg::PHC_RELEASE;
               end else if (shadow_level == '0) begin
                  shadow_phase = (rp == adsr_pkg::RP_SUSTAIN) ? adsr_pkg::PHC_ATTACK
                                                              : adsr_pkg::PHC_OFF;
               end
            end
            adsr_pkg::PHC_SUSUP: begin
               shadow_level = shadow_level + LVL_W'(shadow_cfg.attack_step);
               if (!shadow_gate) begin
                  if (shadow_level > LEVEL_ONE) begin
                     shadow_level = LEVEL_ONE;
                  end
                  shadow_phase = (rp == adsr_pkg::RP_SUSTAIN) ? adsr_pkg::PHC_ATTACK
                                                              : adsr_pkg::PHC_RELEASE;
               end else if (shadow_level >= sus_lim) begin
                  shadow_level = sus_lim;
                  shadow_phase = adsr_pkg::PHC_SUSTAIN;
               end
            end
            adsr_pkg::PHC_RELEASE: begin
               shadow_level = sat_sub(shadow_level, LVL_W'(shadow_cfg.release_step));
               if (shadow_level == '0) begin
                  shadow_phase = (rp == adsr_pkg::RP_RELEASE) ? adsr_pkg::PHC_ATTACK
                                                              : adsr_pkg::PHC_OFF;
               end
            end
            default: begin
               // an update in the off phase silences and disarms the operator
               shadow_level   = '0;
               shadow_enabled = 1'b0;
               shadow_gate    = 1'b0;
            end
         endcase
      end
   endfunction

   // applies one event word and returns the envelope as it stands afterwards
   function automatic envelope_word_type apply_command(input command_word_type cw);
      envelope_word_type ew;
      case (cw.command)
         adsr_pkg::CMD_TICK: begin
            if (shadow_enabled) begin
               advance_envelope();
            end
         end
         adsr_pkg::CMD_KEY_ON: begin
            shadow_enabled = 1'b1;
            if (shadow_phase == adsr_pkg::PHC_OFF) begin
               shadow_divider = shadow_cfg.tick_divider;
               shadow_phase   = adsr_pkg::PHC_ATTACK;
               shadow_gate    = 1'b1;
            end
            if (!cw.legato) begin
               shadow_phase = adsr_pkg::PHC_ATTACK;
               shadow_gate  = 1'b1;
            end
         end
         adsr_pkg::CMD_KEY_OFF: begin
            // sustain looping turns a key off into a fresh attack, gate set
            if (shadow_cfg.repeat_mode == adsr_pkg::RP_SUSTAIN) begin
               shadow_phase = adsr_pkg::PHC_ATTACK;
               shadow_gate  = 1'b1;
            end else begin
               shadow_phase = adsr_pkg::PHC_RELEASE;
               shadow_gate  = 1'b0;
            end
         end
         adsr_pkg::CMD_STOP: begin
            shadow_enabled = 1'b0;
            shadow_phase   = adsr_pkg::PHC_OFF;
            shadow_level   = '0;
            shadow_gate    = 1'b0;
         end
         adsr_pkg::CMD_SET_ENABLE: begin
            shadow_enabled = cw.enable_value;
         end
         default: begin
         end
      endcase
      ew.level  = shadow_level[FRAC_BITS:0];
      ew.phase  = shadow_phase;
      ew.active = shadow_enabled;
      ew.gate   = shadow_gate;
      return ew;
   endfunction

   function automatic void note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t: %s", $realtime, what);
      end
   endfunction

   // ------------------------------------------------------------------------
   // driver: presents queued event words, holds a word until it is taken
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_word_taken) begin
         if (command_queue.size() > 0 && $urandom_range(99) >= req_idle_pct) begin
            next_command = command_queue.pop_front();
            req_tuser  <= next_command.command;
            req_tdata  <= {6'b0, next_command.enable_value, next_command.legato};
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: random stalls, plus a long hold-off counted here on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (holdoff_left > 0) begin
         rsp_tready   <= 1'b0;
         holdoff_left <= holdoff_left - 1;
      end else if (holdoffs_served != holdoff_requests) begin
         holdoffs_served <= holdoff_requests;
         holdoff_left    <= HOLDOFF_LEN;
         rsp_tready      <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // ------------------------------------------------------------------------
   // monitor: register writes, event acceptance and result checking
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      envelope_word_type got;
      envelope_word_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_addr)
               adsr_pkg::CSR_ATTACK_STEP:    shadow_cfg.attack_step    = csr_wdata;
               adsr_pkg::CSR_DECAY_STEP:     shadow_cfg.decay_step     = csr_wdata;
               adsr_pkg::CSR_SUSTAIN_STEP:   shadow_cfg.sustain_step   = csr_wdata;
               adsr_pkg::CSR_RELEASE_STEP:   shadow_cfg.release_step   = csr_wdata;
               adsr_pkg::CSR_SUSTAIN_TARGET: shadow_cfg.sustain_target = csr_wdata;
               adsr_pkg::CSR_REPEAT_MODE:
                  shadow_cfg.repeat_mode = csr_wdata[REPEAT_W-1:0];
               adsr_pkg::CSR_TICK_DIVIDER:
                  shadow_cfg.tick_divider = csr_wdata[DIV_W-1:0];
               default: begin
               end
            endcase
         end
         // results leave only after their event has passed the input and state registers, so check before predicting
         if (rsp_tvalid && rsp_tready) begin
            got.level  = rsp_tdata[FRAC_BITS:0];
            got.phase  = rsp_tdata[FRAC_BITS+PHASE_W:FRAC_BITS+1];
            got.active = rsp_tdata[FRAC_BITS+PHASE_W+1];
            got.gate   = rsp_tdata[FRAC_BITS+PHASE_W+2];
            if (envelope_queue.size() == 0) begin
               note_mismatch($sformatf("result word with nothing expected: level %0d phase %0d",
                                       got.level, got.phase));
            end else begin
               want = envelope_queue.pop_front();
               if (got.level !== want.level || got.phase !== want.phase ||
                   got.active !== want.active || got.gate !== want.gate) begin
                  // level/phase/active/gate
                  note_mismatch($sformatf(
                     "mismatch: expected %0d/%0d/%b/%b, got %0d/%0d/%b/%b",
                     want.level, want.phase, want.active, want.gate,
                     got.level, got.phase, got.active, got.gate));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            envelope_queue.push_back(apply_command(command_word_type'(
               {req_tuser, req_tdata[0], req_tdata[1]})));
            commands_accepted++;
         end
      end
      req_word_taken <= !reset && req_tvalid && req_tready;
   end

   // watchdog: cycles in which no channel moves a word
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
      end
      $display("Some tests failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------

   // called at a falling edge, returns at the falling edge after the write
   task automatic csr_write(input logic [CSR_ADDR_W-1:0] idx,
                            input logic [STEP_W-1:0] val);
      csr_valid <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic program_registers(input adsr_pkg::cfg_type c);
      csr_write(adsr_pkg::CSR_ATTACK_STEP,    c.attack_step);
      csr_write(adsr_pkg::CSR_DECAY_STEP,     c.decay_step);
      csr_write(adsr_pkg::CSR_SUSTAIN_STEP,   c.sustain_step);
      csr_write(adsr_pkg::CSR_RELEASE_STEP,   c.release_step);
      csr_write(adsr_pkg::CSR_SUSTAIN_TARGET, c.sustain_target);
      csr_write(adsr_pkg::CSR_REPEAT_MODE,    STEP_W'(c.repeat_mode));
      csr_write(adsr_pkg::CSR_TICK_DIVIDER,   STEP_W'(c.tick_divider));
      csr_valid <= 1'b0;
   endtask

   task automatic queue_command(input logic [CMD_W-1:0] cmd, input logic legato,
                                input logic en);
      command_word_type cw;
      cw.command      = cmd;
      cw.legato       = legato;
      cw.enable_value = en;
      command_queue.push_back(cw);
      commands_queued++;
   endtask

   // mostly ticks so the envelope gets somewhere between key events
   task automatic queue_random_commands(input int count);
      int               r;
      logic [CMD_W-1:0] cmd;
      repeat (count) begin
         r = $urandom_range(99);
         if (r < 72) begin
            cmd = adsr_pkg::CMD_TICK;
         end else if (r < 80) begin
            cmd = adsr_pkg::CMD_KEY_ON;
         end else if (r < 88) begin
            cmd = adsr_pkg::CMD_KEY_OFF;
         end else if (r < 91) begin
            cmd = adsr_pkg::CMD_STOP;
         end else if (r < 97) begin
            cmd = adsr_pkg::CMD_SET_ENABLE;
         end else begin
            cmd = CMD_W'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
         end
         queue_command(cmd, 1'($urandom_range(1)), ($urandom_range(9) < 7));
      end
   endtask

   // returns at a falling edge with every event taken and every result back
   task automatic wait_until_drained();
      do begin
         @(negedge clock);
      end while (commands_accepted != commands_queued || envelope_queue.size() != 0);
   endtask

   function automatic logic [STEP_W-1:0] pick_step();
      case ($urandom_range(9))
         0:       return '0;
         1:       return STEP_MAX;
         2:       return STEP_W'(LEVEL_ONE);
         3:       return STEP_W'($urandom_range(STEP_MAX));
         default: return STEP_W'($urandom_range(30000, 2000));
      endcase
   endfunction

   initial begin
      adsr_pkg::cfg_type settings;
      int                p;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // a write to the unused index must leave every register alone
      csr_write(CSR_UNUSED, STEP_MAX);

      // directed opening, sustain level above one so decay clamps at one
      settings                = '0;
      settings.attack_step    = 17'd20000;
      settings.decay_step     = 17'd10000;
      settings.release_step   = 17'd30000;
      settings.sustain_target = STEP_MAX;
      settings.repeat_mode    = adsr_pkg::RP_NONE;
      settings.tick_divider   = 16'd1;
      program_registers(settings);

      queue_command(adsr_pkg::CMD_TICK, 1'b1, 1'b1);         // disabled tick
      for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++) begin
         queue_command(CMD_W'(c), 1'b1, 1'b1);               // ignored codes
      end
      queue_command(adsr_pkg::CMD_SET_ENABLE, 1'b0, 1'b1);
      queue_command(adsr_pkg::CMD_TICK, 1'b0, 1'b0);         // off phase update clears flags
      queue_command(adsr_pkg::CMD_KEY_ON, 1'b1, 1'b0);       // legato from off still starts
      queue_command(adsr_pkg::CMD_KEY_ON, 1'b1, 1'b0);       // legato while running: no change
      queue_command(adsr_pkg::CMD_TICK, 1'b0, 1'b0);         // divider running
      queue_command(adsr_pkg::CMD_TICK, 1'b0, 1'b0);
      queue_command(adsr_pkg::CMD_KEY_ON, 1'b0, 1'b1);       // retrigger keeps the level
      repeat (8) queue_command(adsr_pkg::CMD_TICK, 1'b0, 1'b0);   // up through one into sustain
      queue_command(adsr_pkg::CMD_KEY_OFF, 1'b1, 1'b0);
      queue_command(adsr_pkg::CMD_TICK, 1'b0, 1'b1);
      queue_command(adsr_pkg::CMD_TICK, 1'b0, 1'b1);
      queue_command(adsr_pkg::CMD_SET_ENABLE, 1'b0, 1'b0);
      queue_command(adsr_pkg::CMD_TICK, 1'b1, 1'b0);
      queue_command(adsr_pkg::CMD_STOP, 1'b1, 1'b1);
      wait_until_drained();

      for (p = 0; p < PHASE_COUNT; p++) begin
         if (p == 1) begin
            settings = '0;
         end else if (p == 5) begin
            settings = '1;
         end else begin
            settings.attack_step    = pick_step();
            settings.decay_step     = pick_step();
            settings.sustain_step   = ($urandom_range(3) == 0) ? '0 : pick_step();
            settings.release_step   = pick_step();
            settings.sustain_target = pick_step();
            settings.repeat_mode    = REPEAT_W'($urandom_range(7));
            settings.tick_divider   = ($urandom_range(9) == 0) ? DIV_W'($urandom_range(300))
                                                               : DIV_W'($urandom_range(3));
         end
         program_registers(settings);

         case (p % 4)
            0: begin
               req_idle_pct  = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               req_idle_pct  = 73;
               rsp_stall_pct = 0;
            end
            2: begin
               req_idle_pct  = 0;
               rsp_stall_pct = 73;
            end
            default: begin
               req_idle_pct  = 7;
               rsp_stall_pct = 7;
            end
         endcase

         // long receiver hold-off while the sender keeps offering words
         if (p == 0) begin
            holdoff_requests++;
         end
         queue_random_commands(PHASE_ITEMS / 2);
         // sender pause until every result is back, then carry on
         if (p == 4) begin
            wait_until_drained();
         end
         queue_random_commands(PHASE_ITEMS - PHASE_ITEMS / 2);
         wait_until_drained();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && envelope_queue.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
